@@ design/kft_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kft_pkg
// Shared types and constants of the key frequency table: command and status
// codes, controller states and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package kft_pkg;

	localparam int KEY_W     = 32;
	localparam int CMD_W     = 2;
	localparam int CNT_OUT_W = 16;
	localparam int STATUS_W  = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD   = 2'd0,
		CMD_QUERY = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_SAT  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_CMP,
		S_MISS,
		S_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_item;
		logic idx_inc;
		logic rd_en;
		logic hit_upd;
		logic miss_upd;
		logic load_out;
	} ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_lookup;
		logic used_zero;
		logic last_entry;
		logic hit;
		logic out_free;
	} stat_t;

endpackage

@@ design/key_frequency_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_frequency_table_core
// Frequency table of 32-bit keys: add, query and clear beats, one result
// beat for each input beat.
// ----------------------------------------------------------------------------
// The table holds up to ENTRIES keys with a saturating count of COUNT_BITS
// each, in a single-port entry memory that is searched one entry at a time
// (read, then compare). Entries are filled in order and only emptied
// all at once by a clear beat, so a fill count marks the used entries and no
// clearing pass is needed after reset or clear. An add or query that finds
// its key at entry i reads and compares entries 0 to i, one that misses
// searches all entries in use, and a clear, an unknown command or any beat
// on an empty table skips the search. The single read port of the entry
// memory is why the search goes one entry at a time. The result sits in an
// output register, so the next beat is accepted while a result still waits
// on a stalled output.
// ----------------------------------------------------------------------------
module key_frequency_table_core #(
	parameter int ENTRIES    = 64,
	parameter int COUNT_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [kft_pkg::CMD_W-1:0]         cmd,
	input  logic signed [kft_pkg::KEY_W-1:0]  key,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [kft_pkg::CNT_OUT_W-1:0]     count,
	output logic                              found,
	output logic [kft_pkg::STATUS_W-1:0]      status
);

	// Command bundle from the controller and status bundle back to it.
	kft_pkg::ctrl_t ctrl;
	kft_pkg::stat_t stat;

	// The controller sequences each beat: accept, search the used entries,
	// update or allocate, then hand the result to the output register.
	kft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	// The datapath owns the entry memory, fill count and result registers.
	kft_datapath #(
		.ENTRIES    (ENTRIES),
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.key       (key),
		.ctrl      (ctrl),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.count     (count),
		.found     (found),
		.status    (status)
	);

endmodule

@@ design/kft_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kft_ctrl
// Controller of the key frequency table. It walks the used entries one by
// one and tells the datapath when to read, update and hand out a result.
// ----------------------------------------------------------------------------
module kft_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  kft_pkg::stat_t stat,
	output kft_pkg::ctrl_t ctrl
);

	kft_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kft_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctrl     = '0;
		in_stall = 1'b1;
		case (state_q)
			kft_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctrl.load_item = 1'b1;
					state_d = kft_pkg::S_MISS;
				end
			end
			kft_pkg::S_READ: begin
				ctrl.rd_en = 1'b1;
				state_d = kft_pkg::S_CMP;
			end
			kft_pkg::S_CMP: begin
				if (stat.hit) begin
					ctrl.hit_upd = 1'b1;
					state_d = kft_pkg::S_FINISH;
				end else if (stat.last_entry) begin
					state_d = kft_pkg::S_MISS;
				end else begin
					ctrl.idx_inc = 1'b1;
					state_d = kft_pkg::S_READ;
				end
			end
			kft_pkg::S_MISS: begin
				ctrl.miss_upd = 1'b1;
				state_d = kft_pkg::S_FINISH;
			end
			kft_pkg::S_FINISH: begin
				if (stat.out_free) begin
					ctrl.load_out = 1'b1;
					state_d = kft_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = kft_pkg::S_IDLE;
			end
		endcase
		// An add or query with entries in use searches before deciding.
		if (state_q == kft_pkg::S_IDLE && in_valid && stat.is_lookup && !stat.used_zero) begin
			state_d = kft_pkg::S_READ;
		end
	end

endmodule

@@ design/kft_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kft_datapath
// Entry memory, search index, fill count, result registers and the output
// register of the key frequency table.
// ----------------------------------------------------------------------------
module kft_datapath #(
	parameter int ENTRIES    = 64,
	parameter int COUNT_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [kft_pkg::CMD_W-1:0]             cmd,
	input  logic signed [kft_pkg::KEY_W-1:0]      key,
	input  kft_pkg::ctrl_t                        ctrl,
	output kft_pkg::stat_t                        stat,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [kft_pkg::CNT_OUT_W-1:0]         count,
	output logic                                  found,
	output logic [kft_pkg::STATUS_W-1:0]          status
);

	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int USED_W = $clog2(ENTRIES + 1);
	localparam int WORD_W = kft_pkg::KEY_W + COUNT_BITS;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
	localparam logic [USED_W-1:0] USED_FULL = USED_W'(ENTRIES);

	// Entries are allocated in order and only freed all at once, so the used
	// entries always form the range below used_q.
	logic [WORD_W-1:0]             mem_q [ENTRIES];
	logic [WORD_W-1:0]             rd_q;
	logic [kft_pkg::CMD_W-1:0]     cmd_q;
	logic [kft_pkg::KEY_W-1:0]     key_q;
	logic [IDX_W-1:0]              idx_q;
	logic [USED_W-1:0]             used_q;
	logic [COUNT_BITS-1:0]         res_cnt_q;
	logic                          res_found_q;
	logic [kft_pkg::STATUS_W-1:0]  res_status_q;
	logic                          out_valid_q;
	logic [kft_pkg::CNT_OUT_W-1:0] count_q;
	logic                          found_q;
	logic [kft_pkg::STATUS_W-1:0]  status_q;

	logic                          wr_en;
	logic [IDX_W-1:0]              wr_addr;
	logic [WORD_W-1:0]             wr_data;
	logic [kft_pkg::KEY_W-1:0]     rd_key;
	logic [COUNT_BITS-1:0]         rd_cnt;
	logic                          rd_sat;
	logic [COUNT_BITS-1:0]         add_cnt;
	logic                          room;
	logic                          is_add;

	assign rd_key  = rd_q[WORD_W-1:COUNT_BITS];
	assign rd_cnt  = rd_q[COUNT_BITS-1:0];
	assign rd_sat  = (rd_cnt == CNT_MAX);
	assign add_cnt = rd_sat ? rd_cnt : rd_cnt + COUNT_BITS'(1);
	assign room    = (used_q < USED_FULL);
	assign is_add  = (cmd_q == kft_pkg::CMD_ADD);

	// The lookup flag looks at the incoming beat, since the controller decides
	// in the accepting cycle whether a search is needed.
	assign stat.is_lookup  = (cmd == kft_pkg::CMD_ADD) || (cmd == kft_pkg::CMD_QUERY);
	assign stat.used_zero  = (used_q == '0);
	assign stat.last_entry = ((USED_W'(idx_q) + USED_W'(1)) == used_q);
	assign stat.hit        = (rd_key == key_q);
	assign stat.out_free   = !out_valid_q || !out_stall;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = {key_q, add_cnt};
		if (ctrl.hit_upd && is_add) begin
			wr_en = 1'b1;
		end else if (ctrl.miss_upd && is_add && room) begin
			wr_en   = 1'b1;
			wr_addr = used_q[IDX_W-1:0];
			wr_data = {key_q, COUNT_BITS'(1)};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctrl.rd_en) begin
			rd_q <= mem_q[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_item) begin
			cmd_q <= cmd;
			key_q <= key;
		end
		if (ctrl.hit_upd) begin
			res_found_q  <= 1'b1;
			res_cnt_q    <= is_add ? add_cnt : rd_cnt;
			res_status_q <= (is_add && rd_sat) ? kft_pkg::ST_SAT : kft_pkg::ST_OK;
		end else if (ctrl.miss_upd) begin
			res_found_q  <= is_add && room;
			res_cnt_q    <= (is_add && room) ? COUNT_BITS'(1) : '0;
			res_status_q <= (is_add && !room) ? kft_pkg::ST_FULL : kft_pkg::ST_OK;
		end
		if (ctrl.load_out) begin
			count_q  <= kft_pkg::CNT_OUT_W'(res_cnt_q);
			found_q  <= res_found_q;
			status_q <= res_status_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl.load_item) begin
				idx_q <= '0;
			end else if (ctrl.idx_inc) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (ctrl.miss_upd && is_add && room) begin
				used_q <= used_q + USED_W'(1);
			end else if (ctrl.miss_upd && cmd_q == kft_pkg::CMD_CLEAR) begin
				used_q <= '0;
			end
			if (ctrl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign count     = count_q;
	assign found     = found_q;
	assign status    = status_q;

endmodule

@@ tb/tb_key_frequency_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_frequency_table_core
// Self-checking bench for the key frequency table. A shadow table in the
// bench predicts count, found and status for every accepted input beat, and
// each output beat is checked against the oldest prediction. Directed tests
// cover the key extremes, every command and a full table; random tests replay
// short test cases drawn from small key pools.
// ----------------------------------------------------------------------------
module tb_key_frequency_table_core;

	localparam int ENTRIES     = 64;
	localparam int COUNT_BITS  = 16;
	localparam int unsigned COUNT_TOP = (1 << COUNT_BITS) - 1;

	// Command value 3 has no meaning in the block and must answer all zero.
	localparam logic [kft_pkg::CMD_W-1:0] CMD_UNKNOWN = 2'd3;

	// The slowest beat is a miss on a full table, which searches every entry,
	// with stalls on top, and the run sends about five hundred beats. This limit
	// is several times the worst case of that.
	localparam int CYCLE_LIMIT = 1_000_000;

	typedef struct packed {
		logic [kft_pkg::CNT_OUT_W-1:0] count;
		logic                          found;
		kft_pkg::status_t              status;
	} freq_reply_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic [kft_pkg::CMD_W-1:0]        cmd = '0;
	logic signed [kft_pkg::KEY_W-1:0] key = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic [kft_pkg::CNT_OUT_W-1:0]    count;
	logic                             found;
	logic [kft_pkg::STATUS_W-1:0]     status;

	// Shadow copy of the table contents, updated as each input beat is
	// accepted. Entries fill from the lowest free index, and a clear empties
	// them all at once.
	logic [kft_pkg::KEY_W-1:0] shadow_key  [ENTRIES];
	int unsigned               shadow_cnt  [ENTRIES];
	bit                        shadow_used [ENTRIES];
	int                        shadow_fill = 0;

	freq_reply_t               replies_due [$];
	logic [kft_pkg::KEY_W-1:0] key_pool    [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int error_count   = 0;
	int cycle_count   = 0;

	key_frequency_table_core #(
		.ENTRIES   (ENTRIES),
		.COUNT_BITS(COUNT_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.key      (key),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.count    (count),
		.found    (found),
		.status   (status)
	);

	always #5 clk = ~clk;

	// Apply one command to the shadow table and return the reply that the
	// block must give for it. An add that hits bumps the count unless it is
	// already at the top, an add that misses takes the lowest free entry or
	// is dropped when none is left, and a query never creates an entry.
	function automatic freq_reply_t freq_apply(logic [kft_pkg::CMD_W-1:0] op,
			logic [kft_pkg::KEY_W-1:0] k);
		freq_reply_t r;
		int hit_idx;
		int free_idx;
		r = '{count: '0, found: 1'b0, status: kft_pkg::ST_OK};
		hit_idx = -1;
		free_idx = -1;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (shadow_used[i] && shadow_key[i] == k)
				hit_idx = i;
			if (!shadow_used[i])
				free_idx = i;
		end
		case (op)
			kft_pkg::CMD_ADD: begin
				if (hit_idx >= 0) begin
					if (shadow_cnt[hit_idx] >= COUNT_TOP) begin
						shadow_cnt[hit_idx] = COUNT_TOP;
						r.status = kft_pkg::ST_SAT;
					end else begin
						shadow_cnt[hit_idx]++;
					end
					r.count = shadow_cnt[hit_idx][kft_pkg::CNT_OUT_W-1:0];
					r.found = 1'b1;
				end else if (free_idx >= 0 && shadow_fill < ENTRIES) begin
					shadow_key[free_idx]  = k;
					shadow_cnt[free_idx]  = 1;
					shadow_used[free_idx] = 1'b1;
					shadow_fill++;
					r.count = kft_pkg::CNT_OUT_W'(1);
					r.found = 1'b1;
				end else begin
					r.status = kft_pkg::ST_FULL;
				end
			end
			kft_pkg::CMD_QUERY: begin
				if (hit_idx >= 0) begin
					r.count = shadow_cnt[hit_idx][kft_pkg::CNT_OUT_W-1:0];
					r.found = 1'b1;
				end
			end
			kft_pkg::CMD_CLEAR: begin
				for (int i = 0; i < ENTRIES; i++)
					shadow_used[i] = 1'b0;
				shadow_fill = 0;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Present one beat. The task is entered just after a falling edge and
	// returns just after one. The sender may idle first; valid stays high
	// across back-to-back beats and is only lowered during an idle cycle.
	task automatic send_beat(logic [kft_pkg::CMD_W-1:0] op, logic [kft_pkg::KEY_W-1:0] k);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			cmd      <= kft_pkg::CMD_W'($urandom_range(3));
			key      <= $urandom;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= op;
		key      <= k;
		do
			@(posedge clk);
		while (in_stall);
		replies_due.push_back(freq_apply(op, k));
		@(negedge clk);
	endtask

	task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
		error_count++;
		$display("%0t ns: %s expected %0d, actual %0d", $time, what, want, got);
	endtask

	// The receiver stalls at random; the stall is drawn at each falling edge
	// so it holds steady across the following rising edge.
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_idle_pct);

	// Each accepted output beat is matched against the oldest pending reply.
	always @(posedge clk) begin
		freq_reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (replies_due.size() == 0) begin
				error_count++;
				$display("%0t ns: result expected none, actual count %0d found %0d status %0d",
					$time, count, found, status);
			end else begin
				want = replies_due.pop_front();
				if (count !== want.count)
					report_mismatch("count", want.count, count);
				if (found !== want.found)
					report_mismatch("found", want.found, found);
				if (status !== want.status)
					report_mismatch("status", want.status, status);
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Draw a new set of keys for one random test case. Small pools make keys
	// repeat so counts climb; the largest pools overflow the table. The key
	// extremes turn up now and then.
	task automatic fresh_key_pool();
		int size;
		logic [kft_pkg::KEY_W-1:0] k;
		size = ($urandom_range(7) == 0) ? $urandom_range(66, 90) : $urandom_range(2, 24);
		key_pool.delete();
		for (int i = 0; i < size; i++) begin
			k = $urandom;
			if ($urandom_range(7) == 0) begin
				case ($urandom_range(3))
					0: k = 32'h0000_0000;
					1: k = 32'h8000_0000;
					2: k = 32'h7fff_ffff;
					default: k = 32'hffff_ffff;
				endcase
			end
			key_pool.push_back(k);
		end
	endtask

	// Key extremes, every command, hits and misses, clear and the unused
	// command code.
	task automatic test_directed_basics();
		send_beat(kft_pkg::CMD_QUERY, 32'h0000_0000);
		send_beat(kft_pkg::CMD_ADD,   32'h8000_0000);
		send_beat(kft_pkg::CMD_ADD,   32'h7fff_ffff);
		send_beat(kft_pkg::CMD_ADD,   32'h0000_0000);
		send_beat(kft_pkg::CMD_ADD,   32'hffff_ffff);
		send_beat(kft_pkg::CMD_ADD,   32'h8000_0000);
		send_beat(kft_pkg::CMD_ADD,   32'hffff_ffff);
		send_beat(kft_pkg::CMD_QUERY, 32'h8000_0000);
		send_beat(kft_pkg::CMD_QUERY, 32'h7fff_ffff);
		send_beat(kft_pkg::CMD_QUERY, 32'hffff_ffff);
		send_beat(kft_pkg::CMD_QUERY, 32'h0000_0001);
		send_beat(CMD_UNKNOWN,        32'hffff_ffff);
		send_beat(CMD_UNKNOWN,        32'h0000_0000);
		send_beat(kft_pkg::CMD_QUERY, 32'h0000_0000);
		send_beat(kft_pkg::CMD_CLEAR, 32'h7fff_ffff);
		send_beat(kft_pkg::CMD_QUERY, 32'h8000_0000);
		send_beat(kft_pkg::CMD_ADD,   32'h7fff_ffff);
		send_beat(kft_pkg::CMD_QUERY, 32'h7fff_ffff);
		send_beat(kft_pkg::CMD_CLEAR, 32'h0000_0000);
		send_beat(kft_pkg::CMD_CLEAR, 32'hffff_ffff);
	endtask

	// Fill every entry, then add a new key: the add must be dropped and the
	// key must stay absent. A hit on the last entry is the slowest hit.
	task automatic test_table_full();
		logic [kft_pkg::KEY_W-1:0] last_key;
		send_beat(kft_pkg::CMD_CLEAR, $urandom);
		for (int i = 0; i < ENTRIES; i++)
			send_beat(kft_pkg::CMD_ADD, 32'h1357_0000 + i * 32'h0001_0003);
		last_key = 32'h1357_0000 + (ENTRIES - 1) * 32'h0001_0003;
		send_beat(kft_pkg::CMD_ADD,   32'hdead_0001);
		send_beat(kft_pkg::CMD_QUERY, 32'hdead_0001);
		send_beat(kft_pkg::CMD_ADD,   last_key);
		send_beat(kft_pkg::CMD_ADD,   32'hdead_0001);
		send_beat(kft_pkg::CMD_QUERY, last_key);
		send_beat(kft_pkg::CMD_CLEAR, $urandom);
	endtask

	// Random test cases: mostly adds and queries on the current key pool,
	// with a clear starting a new case now and then, plus stray keys and
	// the unused command code as noise.
	task automatic test_random_cases(int beats);
		int roll;
		logic [kft_pkg::CMD_W-1:0] op;
		logic [kft_pkg::KEY_W-1:0] k;
		fresh_key_pool();
		for (int i = 0; i < beats; i++) begin
			roll = $urandom_range(99);
			if (roll < 3)
				op = kft_pkg::CMD_CLEAR;
			else if (roll < 6)
				op = CMD_UNKNOWN;
			else if (roll < 68)
				op = kft_pkg::CMD_ADD;
			else
				op = kft_pkg::CMD_QUERY;
			if ($urandom_range(9) == 0 || op == kft_pkg::CMD_CLEAR || op == CMD_UNKNOWN)
				k = $urandom;
			else
				k = key_pool[$urandom_range(key_pool.size() - 1)];
			send_beat(op, k);
			if (op == kft_pkg::CMD_CLEAR)
				fresh_key_pool();
		end
	endtask

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			shadow_key[i]  = '0;
			shadow_cnt[i]  = 0;
			shadow_used[i] = 1'b0;
		end

		// Reset is held and then released on a falling edge.
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Sender idles often, receiver stalls more often.
		send_idle_pct = 37;
		recv_idle_pct = 56;
		test_directed_basics();
		test_table_full();
		test_random_cases(140);

		// Roles swapped: the block sees a sparse input and a busy output.
		send_idle_pct = 56;
		recv_idle_pct = 37;
		test_random_cases(140);

		// Full rate on both sides.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_cases(140);

		in_valid <= 1'b0;
		while (replies_due.size() != 0)
			@(posedge clk);
		// A stray late result would show up within the longest miss time.
		repeat (2 * ENTRIES + 20) @(posedge clk);

		if (error_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
